// ===== rtl/core/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants for the ray versus box slab test: default field widths
// and the format of the slab distances.
// ----------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

    // default field widths
    localparam int COORD_WIDTH_DEF = 32;
    localparam int DIR_WIDTH_DEF   = 16;

    // slab distances are saturated to this signed width
    localparam int T_WIDTH = 48;

endpackage

`default_nettype wire

// ===== rtl/core/rbst_div.sv =====
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined unsigned restoring divider, one quotient bit per stage. The
// numerator register shifts left and picks up the quotient bits, so after
// NUM_W stages it holds the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 16
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             q_bit;
        logic [NUM_W-1:0] num_next;
        logic [DEN_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign num_in = num;
            assign rem_in = '0;
            assign den_in = den;
        end else begin : g_rest
            assign num_in = num_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        // shift in the next numerator bit and try a subtract
        always_comb begin
            trial    = {rem_in, num_in[NUM_W-1]};
            q_bit    = (trial >= {1'b0, den_in});
            rem_next = q_bit ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
            num_next = {num_in[NUM_W-2:0], q_bit};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= num_next;
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = num_reg[NUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/rbst_lane.sv =====
// ----------------------------------------------------------------------------
// rbst_lane
// One axis of the slab test: distances to both box planes through two
// pipelined dividers, saturation, and ordering into slab entry and exit.
// A zero direction component marks the slab unbounded and checks that the
// origin lies between the bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_lane #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
    parameter int DIR_WIDTH   = rbst_pkg::DIR_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [COORD_WIDTH-1:0] origin,
    input  wire logic signed [DIR_WIDTH-1:0]   dir,
    input  wire logic signed [COORD_WIDTH-1:0] box_lo,
    input  wire logic signed [COORD_WIDTH-1:0] box_hi,
    output logic signed [rbst_pkg::T_WIDTH-1:0] t_near,
    output logic signed [rbst_pkg::T_WIDTH-1:0] t_far,
    output logic                               unbounded,
    output logic                               in_slab
);
    import rbst_pkg::*;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int FRAC_W = DIR_WIDTH - 2;
    localparam int NUM_W  = DIFF_W + FRAC_W;
    localparam int QW     = (NUM_W > T_WIDTH + 1) ? NUM_W : T_WIDTH + 1;
    localparam int DLY    = NUM_W;

    typedef struct packed {
        logic neg_lo;
        logic neg_hi;
        logic zero;
        logic in_slab;
    } side_t;

    // input stage: exact differences, magnitudes and signs
    logic signed [DIFF_W-1:0] dlo, dhi;
    logic        [DIFF_W-1:0] mlo_next, mhi_next;
    logic        [DIR_WIDTH-1:0] dd_next;
    side_t                    side_next;
    logic signed [COORD_WIDTH-1:0] bmin, bmax;

    always_comb begin
        dlo      = DIFF_W'(box_lo) - DIFF_W'(origin);
        dhi      = DIFF_W'(box_hi) - DIFF_W'(origin);
        mlo_next = dlo[DIFF_W-1] ? DIFF_W'(-dlo) : DIFF_W'(dlo);
        mhi_next = dhi[DIFF_W-1] ? DIFF_W'(-dhi) : DIFF_W'(dhi);
        dd_next  = dir[DIR_WIDTH-1] ? DIR_WIDTH'(-dir) : DIR_WIDTH'(dir);
        bmin     = (box_lo < box_hi) ? box_lo : box_hi;
        bmax     = (box_lo < box_hi) ? box_hi : box_lo;
        side_next.neg_lo  = dlo[DIFF_W-1] ^ dir[DIR_WIDTH-1];
        side_next.neg_hi  = dhi[DIFF_W-1] ^ dir[DIR_WIDTH-1];
        side_next.zero    = (dir == '0);
        side_next.in_slab = (origin >= bmin) && (origin <= bmax);
    end

    logic [DIFF_W-1:0]    mlo_reg, mhi_reg;
    logic [DIR_WIDTH-1:0] dd_reg;
    side_t                side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mlo_reg  <= mlo_next;
            mhi_reg  <= mhi_next;
            dd_reg   <= dd_next;
            side_reg <= side_next;
        end
    end

    // dividers for both planes
    logic [NUM_W-1:0] q_lo, q_hi;

    rbst_div #(.NUM_W(NUM_W), .DEN_W(DIR_WIDTH)) u_div_lo (
        .aclk (aclk),
        .en   (en),
        .num  ({mlo_reg, {FRAC_W{1'b0}}}),
        .den  (dd_reg),
        .quo  (q_lo)
    );

    rbst_div #(.NUM_W(NUM_W), .DEN_W(DIR_WIDTH)) u_div_hi (
        .aclk (aclk),
        .en   (en),
        .num  ({mhi_reg, {FRAC_W{1'b0}}}),
        .den  (dd_reg),
        .quo  (q_hi)
    );

    // side info travels alongside the dividers
    side_t side_dly_reg [DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_dly_reg[0] <= side_reg;
            for (int i = 1; i < DLY; i++) begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    // saturate magnitudes and apply signs
    function automatic logic signed [T_WIDTH-1:0] sat_t(input logic [NUM_W-1:0] q,
                                                       input logic neg);
        logic [QW-1:0] qx;
        logic [QW-1:0] cap;
        logic [QW-1:0] mag;
        logic [T_WIDTH-1:0] m;
        qx  = QW'(q);
        cap = neg ? (QW'(1) << (T_WIDTH - 1)) : ((QW'(1) << (T_WIDTH - 1)) - QW'(1));
        mag = (qx > cap) ? cap : qx;
        m   = mag[T_WIDTH-1:0];
        return neg ? $signed(T_WIDTH'(-m)) : $signed(m);
    endfunction

    logic signed [T_WIDTH-1:0] t0_reg, t1_reg;
    side_t                     side_sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg       <= sat_t(q_lo, side_dly_reg[DLY-1].neg_lo);
            t1_reg       <= sat_t(q_hi, side_dly_reg[DLY-1].neg_hi);
            side_sat_reg <= side_dly_reg[DLY-1];
        end
    end

    // order into entry and exit
    logic signed [T_WIDTH-1:0] tn_reg, tx_reg;
    logic                      unb_reg, in_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tn_reg  <= (t0_reg < t1_reg) ? t0_reg : t1_reg;
            tx_reg  <= (t0_reg < t1_reg) ? t1_reg : t0_reg;
            unb_reg <= side_sat_reg.zero;
            in_reg  <= side_sat_reg.in_slab;
        end
    end

    assign t_near    = tn_reg;
    assign t_far     = tx_reg;
    assign unbounded = unb_reg;
    assign in_slab   = in_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box, slab method. Three axis lanes work in
// parallel, a merge stage takes the largest entry and smallest exit.
// ----------------------------------------------------------------------------
// Pipeline: an input stage, one stage per quotient bit in the dividers,
//   saturate, order, merge and the output register.
// Throughput: one request per cycle; the whole pipeline holds while a
//   finished result waits and the consumer is not ready.
// Reset: synchronous active-low aresetn clears all valid bits.
`default_nettype none

module ray_box_slab_test #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
    parameter int DIR_WIDTH   = rbst_pkg::DIR_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_origin_z,
    input  wire logic signed [DIR_WIDTH-1:0]   s_dir_x,
    input  wire logic signed [DIR_WIDTH-1:0]   s_dir_y,
    input  wire logic signed [DIR_WIDTH-1:0]   s_dir_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_lo_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_lo_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_lo_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_hi_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_hi_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_hi_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit
);
    import rbst_pkg::*;

    localparam int LANE_LAT = COORD_WIDTH + 1 + DIR_WIDTH - 2 + 3;

    logic adv;
    logic m_valid_reg, m_hit_reg;

    // pipeline moves whenever the output register is free or being drained
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // axis lanes
    logic signed [COORD_WIDTH-1:0] org [3];
    logic signed [DIR_WIDTH-1:0]   dir [3];
    logic signed [COORD_WIDTH-1:0] blo [3];
    logic signed [COORD_WIDTH-1:0] bhi [3];
    logic signed [T_WIDTH-1:0]     tn  [3];
    logic signed [T_WIDTH-1:0]     tx  [3];
    logic [2:0]                    unb, ins;

    assign org = '{s_origin_x, s_origin_y, s_origin_z};
    assign dir = '{s_dir_x, s_dir_y, s_dir_z};
    assign blo = '{s_box_lo_x, s_box_lo_y, s_box_lo_z};
    assign bhi = '{s_box_hi_x, s_box_hi_y, s_box_hi_z};

    for (genvar a = 0; a < 3; a++) begin : g_lane
        rbst_lane #(.COORD_WIDTH(COORD_WIDTH), .DIR_WIDTH(DIR_WIDTH)) u_lane (
            .aclk      (aclk),
            .en        (adv),
            .origin    (org[a]),
            .dir       (dir[a]),
            .box_lo    (blo[a]),
            .box_hi    (bhi[a]),
            .t_near    (tn[a]),
            .t_far     (tx[a]),
            .unbounded (unb[a]),
            .in_slab   (ins[a])
        );
    end

    // valid bits alongside the lanes
    logic [LANE_LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LANE_LAT-2:0], s_valid};
        end
    end

    // merge: unbounded axes stand in with the extreme distances and flag a miss when the origin lies outside the slab
    localparam logic signed [T_WIDTH-1:0] T_MIN = {1'b1, {(T_WIDTH-1){1'b0}}};
    localparam logic signed [T_WIDTH-1:0] T_MAX = {1'b0, {(T_WIDTH-1){1'b1}}};

    logic signed [T_WIDTH-1:0] en_next, lv_next;
    logic                      miss_next;

    always_comb begin
        en_next   = T_MIN;
        lv_next   = T_MAX;
        miss_next = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (unb[a]) begin
                if (!ins[a]) begin
                    miss_next = 1'b1;
                end
            end else begin
                if (tn[a] > en_next) begin
                    en_next = tn[a];
                end
                if (tx[a] < lv_next) begin
                    lv_next = tx[a];
                end
            end
        end
    end

    logic signed [T_WIDTH-1:0] enter_reg, leave_reg;
    logic                      miss_reg, vld_m_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            enter_reg <= en_next;
            leave_reg <= lv_next;
            miss_reg  <= miss_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_m_reg <= 1'b0;
        end else if (adv) begin
            vld_m_reg <= vld_reg[LANE_LAT-1];
        end
    end

    // hit decision into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_hit_reg <= !miss_reg && (enter_reg <= leave_reg) && (leave_reg >= 0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

    // checks
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg) && $stable(vld_m_reg))
        else $error("pipeline moved during stall");

    a_free_ray_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_m_reg && !miss_reg && enter_reg == T_MIN && leave_reg == T_MAX
        |=> m_valid && m_hit)
        else $error("unbounded ray reported as miss");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray versus box slab test. Each request is
// scored by a local slab predictor and the expected hit bits are queued in
// order; a monitor compares every returned hit. Sender bursts and receiver
// stalls are random, with one long receiver hold-off to fill the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int CW       = rbst_pkg::COORD_WIDTH_DEF;
    localparam int DW       = rbst_pkg::DIR_WIDTH_DEF;
    localparam int LATENCY  = CW + DW + 4;
    localparam int N_RANDOM = 1880;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] dir_t;

    typedef struct {
        coord_t org [3];
        dir_t   dir [3];
        coord_t lo  [3];
        coord_t hi  [3];
    } ray_box_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    dir_t   s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    coord_t s_box_lo_x = '0, s_box_lo_y = '0, s_box_lo_z = '0;
    coord_t s_box_hi_x = '0, s_box_hi_y = '0, s_box_hi_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;

    logic   expected_hits [$];
    int     fail_count = 0;
    longint cycle_count = 0;
    int     burst_left = 0;
    bit     hold_off = 1'b0;
    int     hold_cycles = 0;
    bit     stall_on = 1'b1;

    ray_box_slab_test u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .s_box_lo_x(s_box_lo_x), .s_box_lo_y(s_box_lo_y), .s_box_lo_z(s_box_lo_z),
        .s_box_hi_x(s_box_hi_x), .s_box_hi_y(s_box_hi_y), .s_box_hi_z(s_box_hi_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit)
    );

    always #5 aclk = ~aclk;

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // slab distance: diff * 2^(DW-2) / d, truncated toward zero, 48-bit saturated
    function automatic longint slab_distance(longint diff, longint d);
        bit     neg;
        longint unsigned nd, dd, quo, rem, mag, cap;
        neg = (diff < 0) != (d < 0);
        nd  = (diff < 0) ? -diff : diff;
        dd  = (d < 0) ? -d : d;
        quo = nd / dd;
        rem = nd % dd;
        cap = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
        if (quo >= ((64'd1 << 48) >> (DW - 2)))
            mag = cap;
        else begin
            mag = (quo << (DW - 2)) + ((rem << (DW - 2)) / dd);
            if (mag > cap) mag = cap;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // whole ray versus box decision
    function automatic logic predict_hit(ray_box_t r);
        longint entry, leave, o, d, lo, hi, t0, t1, a, b;
        bit     miss;
        entry = -(64'sd1 <<< 48);
        leave = 64'sd1 <<< 48;
        miss  = 1'b0;
        for (int ax = 0; ax < 3; ax++) begin
            o  = r.org[ax];
            d  = r.dir[ax];
            lo = r.lo[ax];
            hi = r.hi[ax];
            if (d == 0) begin
                a = (lo < hi) ? lo : hi;
                b = (lo < hi) ? hi : lo;
                if (o < a || o > b) miss = 1'b1;
            end else begin
                t0 = slab_distance(lo - o, d);
                t1 = slab_distance(hi - o, d);
                if (((t0 < t1) ? t0 : t1) > entry) entry = (t0 < t1) ? t0 : t1;
                if (((t0 < t1) ? t1 : t0) < leave) leave = (t0 < t1) ? t1 : t0;
            end
        end
        return (!miss && entry <= leave && leave >= 0);
    endfunction

    // offer one request, honoring the burst/gap pattern
    task automatic send_request(ray_box_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_origin_x <= r.org[0]; s_origin_y <= r.org[1]; s_origin_z <= r.org[2];
        s_dir_x    <= r.dir[0]; s_dir_y    <= r.dir[1]; s_dir_z    <= r.dir[2];
        s_box_lo_x <= r.lo[0];  s_box_lo_y <= r.lo[1];  s_box_lo_z <= r.lo[2];
        s_box_hi_x <= r.hi[0];  s_box_hi_y <= r.hi[1];  s_box_hi_z <= r.hi[2];
        expected_hits = {expected_hits, predict_hit(r)};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            3: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 32'h00400000))) - 32'sh00200000;
        endcase
    endfunction

    function automatic dir_t rand_dir();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return dir_t'($urandom());
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            3: return dir_t'($signed($urandom_range(0, 8)) - 4);
            default: return dir_t'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // mostly well-formed: box around a point the ray is aimed near
    function automatic ray_box_t rand_request();
        ray_box_t r;
        coord_t   c, half;
        for (int ax = 0; ax < 3; ax++) begin
            r.org[ax] = rand_coord();
            r.dir[ax] = rand_dir();
            if ($urandom_range(0, 3) != 0) begin
                c    = r.org[ax] + coord_t'($signed(r.dir[ax]) * $urandom_range(0, 64));
                half = $urandom_range(0, 32'h0008_0000);
                r.lo[ax] = c - half;
                r.hi[ax] = c + half;
                if ($urandom_range(0, 9) == 0) begin
                    r.lo[ax] = c + half;
                    r.hi[ax] = c - half;
                end
            end else begin
                r.lo[ax] = rand_coord();
                r.hi[ax] = rand_coord();
            end
        end
        return r;
    endfunction

    function automatic ray_box_t make_request(coord_t o, dir_t d, coord_t lo, coord_t hi);
        ray_box_t r;
        for (int ax = 0; ax < 3; ax++) begin
            r.org[ax] = o; r.dir[ax] = d; r.lo[ax] = lo; r.hi[ax] = hi;
        end
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $error("hit: unexpected result, actual %0b", m_hit);
                fail_count++;
            end else begin
                logic exp_hit;
                exp_hit = expected_hits.pop_front();
                if (m_hit !== exp_hit) begin
                    $error("hit: expected %0b actual %0b", exp_hit, m_hit);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern plus one long hold-off
    always @(negedge aclk) begin
        if (hold_off) begin
            hold_cycles <= hold_cycles + 1;
            m_ready <= 1'b0;
            if (hold_cycles >= 3 * LATENCY) begin
                hold_off <= 1'b0;
                hold_cycles <= 0;
            end
        end else if (!stall_on)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic test_directed();
        ray_box_t r;
        coord_t one;
        one = 32'sh0001_0000;
        // basic hit and miss along all axes
        send_request(make_request('0, 16'sh4000, one, 2 * one));
        send_request(make_request('0, -16'sh4000, one, 2 * one));
        // box behind origin
        send_request(make_request(3 * one, 16'sh4000, one, 2 * one));
        // zero direction, origin on lower bound / on upper bound / outside
        send_request(make_request(one, '0, one, 2 * one));
        send_request(make_request(2 * one, '0, one, 2 * one));
        send_request(make_request(3 * one, '0, one, 2 * one));
        // zero direction with swapped corners
        send_request(make_request(one + 5, '0, 2 * one, one));
        // swapped corners with motion
        send_request(make_request('0, 16'sh4000, 2 * one, one));
        // extremes of every field, saturation
        send_request(make_request(32'sh80000000, 16'sh0001, 32'sh7fffffff, 32'sh7fffffff));
        send_request(make_request(32'sh7fffffff, 16'sh8000, 32'sh80000000, 32'sh80000000));
        send_request(make_request(32'sh80000000, 16'sh7fff, 32'sh80000000, 32'sh7fffffff));
        send_request(make_request(32'sh7fffffff, 16'shffff, 32'sh80000000, 32'sh7fffffff));
        send_request(make_request('1, 16'sh8000, '0, '1));
        // origin exactly on entry plane, entry at zero
        send_request(make_request(one, -16'sh4000, '0, one));
        // mixed axes: one zero, one tiny, one large
        r = make_request('0, '0, -one, one);
        r.dir[1] = 16'sh0001; r.dir[2] = 16'sh7fff;
        send_request(r);
        r.org[0] = 2 * one;
        send_request(r);
    endtask

    task automatic test_random();
        for (int i = 0; i < N_RANDOM; i++) begin
            send_request(rand_request());
            // receiver holds off while the sender keeps offering
            if (i == 400) hold_off = 1'b1;
            if (i == 900) stall_on = 1'b0;
            if (i == 1300) stall_on = 1'b1;
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        s_valid <= 1'b0;
        wait (expected_hits.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0 && expected_hits.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
